// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MRBR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MRBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mrbr_pkg.sv -----
// shared types, codes and widths of the broadcast byte ring
package mrbr_pkg;

    localparam int DEPTH_DEF       = 2048;
    localparam int MAX_READERS_DEF = 8;
    localparam int SLOT_LIMIT      = 8;

    localparam int MODE_W   = 3;
    localparam int ID_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POLL  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd4;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic capture;  // latch the incoming item
        logic execute;  // decide, update pointers, access the ring
        logic load;     // move the result into the output register
    } mrbr_cmd_t;

endpackage

// ----- sv/multi_reader_broadcast_ring.sv -----
// broadcast byte ring: an accepted item passes the capture, execute-stage result and
//   output registers before its result is valid; the sequencer runs one item at a time
//   through capture, ring access (one registered read port) and output load
// a waiting result does not block the next item from being accepted
// reset (aresetn low, synchronous) clears write pointer, read pointers and slot
//   flags at once; ring bytes are left as they are, no clearing pass
module multi_reader_broadcast_ring #(
    parameter int DEPTH       = mrbr_pkg::DEPTH_DEF,
    parameter int MAX_READERS = mrbr_pkg::MAX_READERS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mrbr_pkg::S_TDATA_W-1:0] s_tdata,  // mode[2:0], reader_id[5:3],
                                                     // data_byte[13:6], zero pad
    input  logic                           s_tlast,  // last_of_transfer
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mrbr_pkg::M_TDATA_W-1:0] m_tdata,  // read_byte[7:0], status[10:8],
                                                     // unread_count[21:11],
                                                     // assigned_reader[24:22], zero pad
    output logic                           m_tlast   // echo of last_of_transfer
);
    import mrbr_pkg::*;

    // command bundle from the sequencer
    mrbr_cmd_t cmd;

    // one-item sequencer and output valid
    mrbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // pointers, slot flags, ring store and result payload
    mrbr_datapath #(
        .DEPTH       (DEPTH),
        .MAX_READERS (MAX_READERS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

// ----- sv/mrbr_ctrl.sv -----
// sequencer: one item at a time through capture, execute and output load
module mrbr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output mrbr_pkg::mrbr_cmd_t cmd
);
    import mrbr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready    = (state_reg == ST_IDLE);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.execute = (state_reg == ST_EXEC);
    assign cmd.load    = (state_reg == ST_LOAD) && out_free;
    assign m_tvalid    = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ----- sv/mrbr_datapath.sv -----
// ring store, shared write pointer, per-slot read pointers and result registers
module mrbr_datapath #(
    parameter int DEPTH       = mrbr_pkg::DEPTH_DEF,
    parameter int MAX_READERS = mrbr_pkg::MAX_READERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mrbr_pkg::mrbr_cmd_t             cmd,
    input  logic [mrbr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output logic [mrbr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);
    import mrbr_pkg::*;

    localparam int SLOTS = (MAX_READERS < SLOT_LIMIT) ? MAX_READERS : SLOT_LIMIT;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW    = $clog2(DEPTH);
    localparam int MW    = (PW > COUNT_W) ? PW : COUNT_W;

    localparam logic [PW-1:0] LAST_POS   = PW'(DEPTH - 1);
    localparam logic [PW:0]   DEPTH_X    = (PW + 1)'(DEPTH);
    localparam logic [ID_W:0] SLOTS_X    = (ID_W + 1)'(SLOTS);
    localparam logic [MW-1:0] COUNT_MAXX = MW'(COUNT_MAX);

    // captured item
    logic [MODE_W-1:0] mode_reg;
    logic [ID_W-1:0]   slot_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // ring state
    logic [BYTE_W-1:0] ring [DEPTH];
    logic [PW-1:0]     wp_reg, wp_next;
    logic [PW-1:0]     rp_reg  [SLOTS];
    logic [PW-1:0]     rp_next [SLOTS];
    logic [SLOTS-1:0]  active_reg, active_next;

    // execute-stage results
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;
    logic [ID_W-1:0]     res_assigned_reg, res_assigned_next;
    logic                res_rd_ok_reg, res_rd_ok_next;
    logic [BYTE_W-1:0]   mem_q_reg;

    // output register
    logic [BYTE_W-1:0]   out_byte_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [ID_W-1:0]     out_assigned_reg;
    logic                out_last_reg;

    logic [SW-1:0] idx, free_idx;
    logic          live, full, found, do_write;
    logic [PW-1:0] rp_sel, rp_inc, wp_inc;
    logic [PW-1:0] cnt_wp, cnt_rp;
    logic          cnt_en;
    logic [PW:0]   diff;
    logic [PW-1:0] pend;
    logic [MW-1:0] pend_x;

    assign idx    = slot_reg[SW-1:0];
    assign live   = ({1'b0, slot_reg} < SLOTS_X) && active_reg[idx];
    assign rp_sel = rp_reg[idx];
    assign rp_inc = (rp_sel == LAST_POS) ? '0 : rp_sel + 1'b1;
    assign wp_inc = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;

    // a slot is full when its pointer sits just past the write pointer
    always_comb begin
        full = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (active_reg[i] && (rp_reg[i] == wp_inc)) begin
                full = 1'b1;
            end
        end
    end

    // lowest free slot
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                found    = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    always_comb begin
        wp_next           = wp_reg;
        rp_next           = rp_reg;
        active_next       = active_reg;
        res_status_next   = ST_OK;
        res_assigned_next = '0;
        res_rd_ok_next    = 1'b0;
        do_write          = 1'b0;
        cnt_en            = 1'b0;
        cnt_wp            = wp_reg;
        cnt_rp            = rp_sel;
        unique case (mode_reg)
            MODE_WRITE: begin
                if (!live) begin
                    res_status_next = ST_INACTIVE;
                end else begin
                    cnt_en = 1'b1;
                    if (full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        do_write = 1'b1;
                        wp_next  = wp_inc;
                        cnt_wp   = wp_inc;
                    end
                end
            end
            MODE_READ: begin
                if (!live) begin
                    res_status_next = ST_INACTIVE;
                end else if (rp_sel == wp_reg) begin
                    res_status_next = ST_EMPTY;
                end else begin
                    res_rd_ok_next = 1'b1;
                    rp_next[idx]   = rp_inc;
                    cnt_en         = 1'b1;
                    cnt_rp         = rp_inc;
                end
            end
            MODE_OPEN: begin
                if (!found) begin
                    res_status_next = ST_NOSLOT;
                end else begin
                    active_next[free_idx] = 1'b1;
                    rp_next[free_idx]     = wp_reg;
                    res_assigned_next     = ID_W'(free_idx);
                end
            end
            MODE_CLOSE: begin
                if (!live) begin
                    res_status_next = ST_INACTIVE;
                end else begin
                    active_next[idx] = 1'b0;
                end
            end
            MODE_POLL: begin
                if (!live) begin
                    res_status_next = ST_INACTIVE;
                end else begin
                    cnt_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // unread bytes modulo the ring depth, saturated to the field width
    assign diff   = {1'b0, cnt_wp} - {1'b0, cnt_rp};
    assign pend   = diff[PW] ? PW'(diff + DEPTH_X) : diff[PW-1:0];
    assign pend_x = MW'(pend);
    assign res_count_next = !cnt_en ? '0
                          : (pend_x > COUNT_MAXX) ? COUNT_MAX : pend_x[COUNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= s_tdata[MODE_W-1:0];
            slot_reg <= s_tdata[MODE_W+ID_W-1:MODE_W];
            byte_reg <= s_tdata[MODE_W+ID_W+BYTE_W-1:MODE_W+ID_W];
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            active_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                rp_reg[i] <= '0;
            end
        end else if (cmd.execute) begin
            wp_reg     <= wp_next;
            active_reg <= active_next;
            rp_reg     <= rp_next;
        end
    end

    // ring: write on an accepted write, registered read of the selected slot on every execute
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            if (do_write) begin
                ring[wp_reg] <= byte_reg;
            end
            mem_q_reg <= ring[rp_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            res_status_reg   <= res_status_next;
            res_count_reg    <= res_count_next;
            res_assigned_reg <= res_assigned_next;
            res_rd_ok_reg    <= res_rd_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_byte_reg     <= res_rd_ok_reg ? mem_q_reg : '0;
            out_status_reg   <= res_status_reg;
            out_count_reg    <= res_count_reg;
            out_assigned_reg <= res_assigned_reg;
            out_last_reg     <= last_reg;
        end
    end

    assign m_tdata = {
        (M_TDATA_W - BYTE_W - STATUS_W - COUNT_W - ID_W)'(0),
        out_assigned_reg, out_count_reg, out_status_reg, out_byte_reg
    };
    assign m_tlast = out_last_reg;

endmodule

// ----- sv/mrbr_checker.sv -----
// port-level checks for the broadcast byte ring, bound to the top level
`include "assert_macros.svh"

module mrbr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mrbr_pkg::M_TDATA_W-1:0] m_tdata
);
    import mrbr_pkg::*;

    // a stalled result keeps its payload
    `MRBR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one item in flight: no accept right after an accept
    `MRBR_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item accepted back to back")

    // a failed item delivers no byte
    `MRBR_ASSERT_NOW(a_byte_zero, m_tvalid && (m_tdata[10:8] != ST_OK), m_tdata[7:0] == 8'd0, "byte on failed item")

    // a slot number only comes with a good status
    `MRBR_ASSERT_NOW(a_assigned, m_tvalid && (m_tdata[24:22] != 3'd0), m_tdata[10:8] == ST_OK, "slot given on failure")

endmodule

bind multi_reader_broadcast_ring mrbr_checker u_mrbr_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for the broadcast byte ring: queued items, running predictor, stream checks
module tb;
    import mrbr_pkg::*;

    // input item and result item as the ring sees them
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   reader_id;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } ring_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_byte;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  unread_count;
        logic [ID_W-1:0]     assigned_reader;
        logic                last;
    } ring_reply_t;

    // unread count at which a write is refused, one entry always stays free
    localparam logic [COUNT_W-1:0] FULL_LEVEL = COUNT_W'(DEPTH_DEF - 1);
    localparam int RANDOM_ITEMS = 1024;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 5000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    ring_cmd_t   cmd_queue[$];    // items still to be driven
    ring_reply_t reply_queue[$];  // predicted results, oldest first
    ring_cmd_t   cur_cmd;
    ring_reply_t want;

    // predictor state, 11-bit pointers wrap by themselves since the ring holds 2048 bytes
    logic [BYTE_W-1:0]  ring_bytes [DEPTH_DEF];
    logic [COUNT_W-1:0] wr_ptr = '0;
    logic [COUNT_W-1:0] rd_ptr [MAX_READERS_DEF];
    logic [MAX_READERS_DEF-1:0] slot_open = '0;

    // slots the stimulus expects to be open, used only to aim reads and writes
    logic [MAX_READERS_DEF-1:0] plan_mask = '0;

    int total_items;
    int n_sent = 0;
    int send_idle, recv_idle;
    int errors = 0;
    int quiet = 0;

    multi_reader_broadcast_ring DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // unread bytes of one slot
    function automatic logic [COUNT_W-1:0] unread_of(input int slot);
        return wr_ptr - rd_ptr[slot];
    endfunction

    // apply one accepted item to the predictor state and return its result
    function automatic ring_reply_t ring_apply(input ring_cmd_t it);
        ring_reply_t r;
        logic        live;
        r      = '0;
        r.last = it.last;
        live   = slot_open[it.reader_id];
        case (it.mode)
            MODE_WRITE: begin
                if (!live) begin
                    r.status = ST_INACTIVE;
                end else begin
                    r.status = ST_OK;
                    // any lagging reader at the limit blocks the writer
                    for (int i = 0; i < MAX_READERS_DEF; i++) begin
                        if (slot_open[i] && unread_of(i) >= FULL_LEVEL)
                            r.status = ST_FULL;
                    end
                    if (r.status == ST_OK) begin
                        ring_bytes[wr_ptr] = it.data_byte;
                        wr_ptr = wr_ptr + 1'b1;
                    end
                    r.unread_count = unread_of(it.reader_id);
                end
            end
            MODE_READ: begin
                if (!live) begin
                    r.status = ST_INACTIVE;
                end else if (unread_of(it.reader_id) == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_byte = ring_bytes[rd_ptr[it.reader_id]];
                    rd_ptr[it.reader_id] = rd_ptr[it.reader_id] + 1'b1;
                    r.unread_count = unread_of(it.reader_id);
                end
            end
            MODE_OPEN: begin
                // lowest free slot, the requested id plays no part
                r.status = ST_NOSLOT;
                for (int i = 0; i < MAX_READERS_DEF && i < SLOT_LIMIT; i++) begin
                    if (r.status == ST_NOSLOT && !slot_open[i]) begin
                        slot_open[i] = 1'b1;
                        rd_ptr[i] = wr_ptr;
                        r.status = ST_OK;
                        r.assigned_reader = ID_W'(i);
                    end
                end
            end
            MODE_CLOSE: begin
                if (!live) r.status = ST_INACTIVE;
                else slot_open[it.reader_id] = 1'b0;
            end
            MODE_POLL: begin
                if (!live) r.status = ST_INACTIVE;
                else r.unread_count = unread_of(it.reader_id);
            end
            default: ;  // spare modes do nothing
        endcase
        return r;
    endfunction

    // append an item and keep the stimulus view of open slots up to date
    function automatic void queue_item(input logic [MODE_W-1:0] mode,
                                       input logic [ID_W-1:0] id,
                                       input logic [BYTE_W-1:0] data,
                                       input logic last);
        logic placed;
        placed = 1'b0;
        cmd_queue.push_back('{mode: mode, reader_id: id, data_byte: data, last: last});
        if (mode == MODE_OPEN) begin
            for (int i = 0; i < MAX_READERS_DEF; i++) begin
                if (!placed && !plan_mask[i]) begin
                    plan_mask[i] = 1'b1;
                    placed = 1'b1;
                end
            end
        end else if (mode == MODE_CLOSE) begin
            plan_mask[id] = 1'b0;
        end
    endfunction

    // random open slot, or any slot when none is open
    function automatic logic [ID_W-1:0] pick_open_id();
        logic [ID_W-1:0] id;
        id = ID_W'($urandom_range(MAX_READERS_DEF - 1));
        if (plan_mask != 0) begin
            while (!plan_mask[id]) id = ID_W'($urandom_range(MAX_READERS_DEF - 1));
        end
        return id;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endtask

    // idle shares: sender light and receiver heavy, then swapped, then none
    always_comb begin
        if (n_sent < total_items / 3) begin
            send_idle = 12;
            recv_idle = 62;
        end else if (n_sent < 2 * total_items / 3) begin
            send_idle = 62;
            recv_idle = 12;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    end

    // driver: predict on accept, then present the next item or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                reply_queue.push_back(ring_apply(cur_cmd));
                n_sent <= n_sent + 1;
            end
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                cur_cmd = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, cur_cmd.data_byte, cur_cmd.reader_id, cur_cmd.mode};
                s_tlast  <= cur_cmd.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest prediction, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_queue.size() == 0) begin
                    $error("result item with no item pending");
                    errors++;
                end else begin
                    want = reply_queue.pop_front();
                    check_field("read_byte", 32'(want.read_byte), 32'(m_tdata[7:0]));
                    check_field("status", 32'(want.status), 32'(m_tdata[10:8]));
                    check_field("unread_count", 32'(want.unread_count),
                                32'(m_tdata[21:11]));
                    check_field("assigned_reader", 32'(want.assigned_reader),
                                32'(m_tdata[24:22]));
                    check_field("pad", 0, 32'(m_tdata[M_TDATA_W-1:25]));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int          target;
        int          roll;
        int          len;
        logic [ID_W-1:0] id;

        // directed: slots never opened
        queue_item(MODE_READ, 3'd0, 8'd0, 1'b0);
        queue_item(MODE_WRITE, 3'd7, 8'hff, 1'b1);
        queue_item(MODE_CLOSE, 3'd3, 8'd0, 1'b0);
        queue_item(MODE_POLL, 3'd5, 8'd0, 1'b1);
        // spare modes
        queue_item(MODE_POLL + 3'd1, 3'd1, 8'h5a, 1'b0);
        queue_item(MODE_POLL + 3'd2, 3'd6, 8'ha5, 1'b1);
        queue_item(MODE_POLL + 3'd3, 3'd7, 8'hff, 1'b0);
        // one reader, byte extremes, read until empty
        queue_item(MODE_OPEN, 3'd7, 8'd0, 1'b0);
        queue_item(MODE_WRITE, 3'd0, 8'h00, 1'b0);
        queue_item(MODE_WRITE, 3'd0, 8'hff, 1'b1);
        queue_item(MODE_POLL, 3'd0, 8'd0, 1'b0);
        for (int i = 0; i < 3; i++) queue_item(MODE_READ, 3'd0, 8'd0, i == 2);
        // take every slot, then one too many
        for (int i = 1; i < MAX_READERS_DEF; i++) queue_item(MODE_OPEN, 3'd0, 8'd0, 1'b0);
        queue_item(MODE_OPEN, 3'd2, 8'd0, 1'b1);
        // free the top slot, reopen it, write through another slot and read
        queue_item(MODE_CLOSE, 3'd7, 8'd0, 1'b0);
        queue_item(MODE_OPEN, 3'd0, 8'd0, 1'b0);
        queue_item(MODE_WRITE, 3'd3, 8'ha5, 1'b1);
        queue_item(MODE_READ, 3'd7, 8'd0, 1'b1);

        // random: mostly write and read bursts on open slots, some noise
        target = cmd_queue.size() + RANDOM_ITEMS;
        while (cmd_queue.size() < target) begin
            roll = $urandom_range(99);
            len  = $urandom_range(1, 24);
            id   = ($urandom_range(9) == 0) ? ID_W'($urandom_range(7)) : pick_open_id();
            if (plan_mask == 0 || roll < 10) begin
                queue_item(MODE_OPEN, ID_W'($urandom_range(7)),
                           BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (roll < 45) begin
                for (int k = 0; k < len; k++)
                    queue_item(MODE_WRITE, id, BYTE_W'($urandom_range(255)), k == len - 1);
            end else if (roll < 78) begin
                for (int k = 0; k < len; k++)
                    queue_item(MODE_READ, id, BYTE_W'($urandom_range(255)), k == len - 1);
            end else if (roll < 86) begin
                queue_item(MODE_CLOSE, id, BYTE_W'($urandom_range(255)),
                           1'($urandom_range(1)));
            end else if (roll < 93) begin
                queue_item(MODE_POLL, ID_W'($urandom_range(7)),
                           BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                queue_item(MODE_W'($urandom_range(7)), ID_W'($urandom_range(7)),
                           BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
        total_items = cmd_queue.size();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // all items accepted and all results seen, then a short drain
        do @(negedge aclk);
        while (cmd_queue.size() > 0 || s_tvalid || reply_queue.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/mrbr_pkg.sv
sv/mrbr_ctrl.sv
sv/mrbr_datapath.sv
sv/multi_reader_broadcast_ring.sv
sv/mrbr_checker.sv
dv/tb.sv
